### rtl/core/mbd_pkg.sv
// Shared types and constants for the multi-button debouncer.
// Standalone package; every other file in rtl/core imports it.
package mbd_pkg;

  // Default button count and the width of the pin and mask fields
  localparam int NUM_BUTTONS_DEF = 8;
  localparam int FIELD_LANES     = 8;

  // Request codes carried in req_type
  localparam logic [1:0] REQ_EDGE = 2'd0;
  localparam logic [1:0] REQ_TICK = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] CFG_ACTIVE  = 2'd0;
  localparam logic [1:0] CFG_PRESS   = 2'd1;
  localparam logic [1:0] CFG_RELEASE = 2'd2;

  // Configuration reset values
  localparam logic [3:0]  ACTIVE_RST  = 4'd1;
  localparam logic [15:0] PRESS_RST   = 16'd20;
  localparam logic [15:0] RELEASE_RST = 16'd100;

  typedef enum logic [2:0] {
    ST_UP        = 3'b001,
    ST_DOWN      = 3'b010,
    ST_UNCERTAIN = 3'b100
  } btn_state_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic [2:0] button_index;
    logic [7:0] pin_levels;
  } in_item_t;

  typedef struct packed {
    logic       handled;
    logic       read_ok;
    logic [7:0] pressed_mask;
    logic       event_pending;
  } out_item_t;

  // Per-lane strobes from the top level
  typedef struct packed {
    logic edge_hit;
    logic tick;
    logic pin_low;
  } lane_ctl_t;

  // Per-lane findings for the merge stage
  typedef struct packed {
    logic is_down;
    logic press;
  } lane_stat_t;

  // Transaction control for the merge stage
  typedef struct packed {
    logic       accept;
    logic [1:0] req_type;
    logic [2:0] button_index;
  } merge_ctl_t;

endpackage

### rtl/core/mbd_lane.sv
// One button lane: debounce state, countdown timer and armed flag.
// Depends on mbd_pkg.
module mbd_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  mbd_pkg::lane_ctl_t ctl,
  input  logic [15:0]        press_dly,
  input  logic [15:0]        rel_dly,
  output mbd_pkg::lane_stat_t stat
);
  import mbd_pkg::*;

  btn_state_t  st_r, st_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        armed_r, armed_nxt;
  logic [15:0] dec;
  logic        press;

  always_comb begin
    st_nxt    = st_r;
    cnt_nxt   = cnt_r;
    armed_nxt = armed_r;
    press     = 1'b0;
    dec       = (cnt_r != 16'd0) ? (cnt_r - 16'd1) : cnt_r;
    if (ctl.edge_hit) begin
      if (st_r == ST_UP) begin
        st_nxt    = ST_UNCERTAIN;
        cnt_nxt   = press_dly;
        armed_nxt = 1'b1;
      end
    end else if (ctl.tick && armed_r) begin
      cnt_nxt = dec;
      if (dec == 16'd0) begin
        armed_nxt = 1'b0;
        if (ctl.pin_low) begin
          // still held: confirm a pending press, re-arm for the next sample
          if (st_r == ST_UNCERTAIN) begin
            st_nxt = ST_DOWN;
            press  = 1'b1;
          end
          cnt_nxt   = rel_dly;
          armed_nxt = 1'b1;
        end else begin
          st_nxt = ST_UP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_UP;
      cnt_r   <= '0;
      armed_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      cnt_r   <= cnt_nxt;
      armed_r <= armed_nxt;
    end
  end

  assign stat.is_down = (st_r == ST_DOWN);
  assign stat.press   = press;

endmodule

### rtl/core/mbd_merge.sv
// Merge stage: pending-event flag, pressed mask and result fields.
// Depends on mbd_pkg; fed by the mbd_lane instances.
module mbd_merge #(
  parameter int LANES = mbd_pkg::FIELD_LANES
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mbd_pkg::merge_ctl_t  ctl,
  input  logic [3:0]           active_buttons,
  input  logic [LANES-1:0]     down_vec,
  input  logic [LANES-1:0]     press_vec,
  output mbd_pkg::out_item_t   result
);
  import mbd_pkg::*;

  logic       flag_r, flag_nxt;
  logic [7:0] mask;
  logic       idx_ok;

  always_comb begin
    mask = '0;
    for (int i = 0; i < LANES; i++) begin
      mask[i] = down_vec[i] && (active_buttons > 4'(i));
    end
  end

  assign idx_ok = ({1'b0, ctl.button_index} < active_buttons) &&
                  (int'(ctl.button_index) < LANES);

  always_comb begin
    flag_nxt            = flag_r;
    result.handled      = 1'b0;
    result.read_ok      = 1'b0;
    result.pressed_mask = '0;
    case (ctl.req_type)
      REQ_EDGE: begin
        result.handled = idx_ok;
      end
      REQ_TICK: begin
        if (ctl.accept && (|press_vec)) flag_nxt = 1'b1;
      end
      REQ_READ: begin
        if (flag_r) begin
          result.read_ok      = 1'b1;
          result.pressed_mask = mask;
          if (ctl.accept) flag_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
    result.event_pending = flag_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flag_r <= 1'b0;
    end else begin
      flag_r <= flag_nxt;
    end
  end

endmodule

### rtl/core/multi_button_debouncer.sv
// Multi-button debouncer top level: config registers, button lanes, merge, output register.
// Depends on mbd_pkg, mbd_lane and mbd_merge.
//
// Usage:
//   Input channel (in_valid / in_stall / in_data) carries one request per transaction:
//   an edge event on one button, a timer tick that advances every armed timer, or a
//   status read that, with an event pending, clears the flag and returns the pressed mask.
//   Output channel (out_valid / out_stall / out_data) returns exactly one result per
//   request, in order. Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data)
//   writes active_buttons, press_delay_ticks or release_delay_ticks; write only while
//   no request is in flight. cfg_ready is always high; unknown indexes are dropped.
// Timing:
//   Each request is handled by the per-button lanes working side by side, and its result
//   appears in the output register the next cycle. While out_stall is low, one request
//   per cycle is sustained; the single lane update and the merge stage fix that.
// Reset (rst_n low, synchronous): all buttons up, timers idle, pending flag clear,
//   registers back to 1 / 20 / 100, output register empty.
// Stall: while a result waits under out_stall, in_stall is raised; a result taken in
//   the same cycle frees the register for the next request.
module multi_button_debouncer #(
  parameter int NUM_BUTTONS = mbd_pkg::NUM_BUTTONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  mbd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output mbd_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import mbd_pkg::*;

  // Only the lanes that fit in the pin and mask fields hold state
  localparam int LANES = (NUM_BUTTONS < FIELD_LANES) ? NUM_BUTTONS : FIELD_LANES;

  logic [3:0]  active_r;
  logic [15:0] press_r, release_r;
  logic [15:0] press_dly, rel_dly;

  logic        accept;
  logic        cfg_wr;
  logic        out_valid_r;
  out_item_t   out_data_r;
  out_item_t   result;

  logic [LANES-1:0] down_vec, press_vec;
  merge_ctl_t       mctl;

  // Hold the input while a result waits and the receiver stalls
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // Config writes: always ready, unknown index dropped
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= ACTIVE_RST;
      press_r   <= PRESS_RST;
      release_r <= RELEASE_RST;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_ACTIVE:  active_r  <= cfg_data[3:0];
        CFG_PRESS:   press_r   <= cfg_data;
        CFG_RELEASE: release_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A zero delay acts as one tick
  assign press_dly = (press_r   == 16'd0) ? 16'd1 : press_r;
  assign rel_dly   = (release_r == 16'd0) ? 16'd1 : release_r;

  // Lanes: one per button, all updated by the same transaction
  for (genvar i = 0; i < LANES; i++) begin : g_lane
    lane_ctl_t  lctl;
    lane_stat_t lstat;

    assign lctl.edge_hit = accept && (in_data.req_type == REQ_EDGE) &&
                           (in_data.button_index == 3'(i)) && (active_r > 4'(i));
    assign lctl.tick     = accept && (in_data.req_type == REQ_TICK);
    assign lctl.pin_low  = ~in_data.pin_levels[i];

    mbd_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (lctl),
      .press_dly (press_dly),
      .rel_dly   (rel_dly),
      .stat      (lstat)
    );

    assign down_vec[i]  = lstat.is_down;
    assign press_vec[i] = lstat.press;
  end

  // Merge lane findings into the result and the pending flag
  assign mctl.accept       = accept;
  assign mctl.req_type     = in_data.req_type;
  assign mctl.button_index = in_data.button_index;

  mbd_merge #(
    .LANES (LANES)
  ) u_merge (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (mctl),
    .active_buttons (active_r),
    .down_vec       (down_vec),
    .press_vec      (press_vec),
    .result         (result)
  );

  // Output register: load on accept, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/mbd_checker.sv
// Port-level checker for multi_button_debouncer, bound to the top level.
// Depends on mbd_pkg.
module mbd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input mbd_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input mbd_pkg::out_item_t out_data
);
  import mbd_pkg::*;

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Every accepted transaction yields a result the next cycle
  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted transaction produced no result");

  // A successful read clears the pending flag
  a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.read_ok |-> !out_data.event_pending)
    else $error("read left event pending");

  // Mask only travels with a successful read
  a_mask_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.read_ok |-> out_data.pressed_mask == 8'd0)
    else $error("pressed mask without read");

endmodule

bind multi_button_debouncer mbd_checker u_mbd_checker (.*);

### tb/sv/tb.sv
// Self-checking testbench for the multi-button debouncer: a scoreboard class that
// predicts each status transaction, plus tasks that drive requests and register writes.
// Depends on mbd_pkg and the multi_button_debouncer RTL.
`timescale 1ns / 100ps

import mbd_pkg::*;

class debounce_scoreboard;
  // Lanes the pin and mask fields can carry
  localparam int LANES = (NUM_BUTTONS_DEF < FIELD_LANES) ? NUM_BUTTONS_DEF : FIELD_LANES;

  btn_state_t  btn[LANES];
  logic [15:0] remaining[LANES];
  bit          armed[LANES];
  bit          press_flag;
  logic [3:0]  active_cnt;
  logic [15:0] press_ticks;
  logic [15:0] release_ticks;

  out_item_t   awaited_status[$];
  int          errors;
  int          requests;
  int          checked;
  int          status_reads;
  int          presses;

  function new();
    for (int i = 0; i < LANES; i++) begin
      btn[i]       = ST_UP;
      remaining[i] = '0;
      armed[i]     = 1'b0;
    end
    press_flag    = 1'b0;
    active_cnt    = ACTIVE_RST;
    press_ticks   = PRESS_RST;
    release_ticks = RELEASE_RST;
  endfunction

  function int unsigned in_use();
    return (active_cnt > LANES) ? LANES : active_cnt;
  endfunction

  function logic [15:0] at_least_one(logic [15:0] ticks);
    return (ticks == 0) ? 16'd1 : ticks;
  endfunction

  function void note_reg_write(logic [1:0] idx, logic [15:0] data);
    case (idx)
      CFG_ACTIVE:  active_cnt    = data[3:0];
      CFG_PRESS:   press_ticks   = data;
      CFG_RELEASE: release_ticks = data;
      default: ;
    endcase
  endfunction

  // Advance the debouncer by one request and queue the status it returns
  function void note_request(in_item_t req);
    out_item_t st;
    st = '0;
    requests++;
    case (req.req_type)
      REQ_EDGE: begin
        if (req.button_index < in_use()) begin
          st.handled = 1'b1;
          if (btn[req.button_index] == ST_UP) begin
            btn[req.button_index]       = ST_UNCERTAIN;
            remaining[req.button_index] = at_least_one(press_ticks);
            armed[req.button_index]     = 1'b1;
          end
        end
      end
      REQ_TICK: begin
        for (int i = 0; i < LANES; i++) begin
          if (!armed[i]) continue;
          if (remaining[i] > 0) remaining[i] = remaining[i] - 16'd1;
          if (remaining[i] != 0) continue;
          armed[i] = 1'b0;
          if (!req.pin_levels[i]) begin
            if (btn[i] == ST_UNCERTAIN) begin
              btn[i]     = ST_DOWN;
              press_flag = 1'b1;
              presses++;
            end
            remaining[i] = at_least_one(release_ticks);
            armed[i]     = 1'b1;
          end else begin
            btn[i] = ST_UP;
          end
        end
      end
      REQ_READ: begin
        if (press_flag) begin
          press_flag = 1'b0;
          st.read_ok = 1'b1;
          status_reads++;
          for (int i = 0; i < in_use(); i++)
            if (btn[i] == ST_DOWN) st.pressed_mask[i] = 1'b1;
        end
      end
      default: ;
    endcase
    st.event_pending = press_flag;
    awaited_status.push_back(st);
  endfunction

  function void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  function void check_result(out_item_t got);
    out_item_t want;
    if (awaited_status.size() == 0) begin
      errors++;
      $display("%0t: unexpected result: expected none, actual 0x%0h", $time, got);
      return;
    end
    want = awaited_status.pop_front();
    checked++;
    cmp_field("handled", want.handled, got.handled);
    cmp_field("read_ok", want.read_ok, got.read_ok);
    cmp_field("pressed_mask", want.pressed_mask, got.pressed_mask);
    cmp_field("event_pending", want.event_pending, got.event_pending);
  endfunction
endclass

module tb;
  // Request code 3 is unused by the block; register index 3 does not exist
  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam logic [1:0] CFG_NONE = 2'd3;
  localparam int LANES      = (NUM_BUTTONS_DEF < FIELD_LANES) ? NUM_BUTTONS_DEF : FIELD_LANES;
  localparam int CYCLE_CAP  = 200000;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  bit         no_idle   = 1'b0;   // hold both sides busy while set
  logic [7:0] held_low  = '0;     // buttons the virtual user is holding down
  int         cycles    = 0;

  debounce_scoreboard sb = new();

  multi_button_debouncer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Stall the result side in about one cycle of five, except during quiet stretches
  always @(posedge clk) begin
    out_stall <= !no_idle && ($urandom_range(0, 99) < 20);
  end

  // Watch all three channels; every value read here is the one present at the edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.note_reg_write(cfg_index, cfg_data);
      if (in_valid && !in_stall) sb.note_request(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("%0t: timeout with %0d status transactions outstanding", $time,
               sb.awaited_status.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic in_item_t mk(logic [1:0] req, logic [2:0] idx, logic [7:0] pins);
    in_item_t it;
    it.req_type     = req;
    it.button_index = idx;
    it.pin_levels   = pins;
    return it;
  endfunction

  // Offer one request transaction; at random, idle first with valid low
  task automatic offer(input in_item_t it);
    if (!no_idle && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted status has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.awaited_status.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Write one register once the block is idle
  task automatic write_reg_port(input logic [1:0] idx, input logic [15:0] data);
    settle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One setting of the registers followed by a stream of user-like activity:
  // buttons go down and up with edge events, ticks sample the pins, reads poll
  // the status; now and then bounce noise, stray edges and unused requests.
  task automatic run_phase(input logic [3:0] act, input logic [15:0] press_d,
                           input logic [15:0] rel_d, input int count, input bit quiet);
    int unsigned lim;
    int unsigned roll;
    logic [2:0]  b;
    logic [7:0]  pins;
    write_reg_port(CFG_ACTIVE, {12'($urandom), act});
    write_reg_port(CFG_PRESS, press_d);
    write_reg_port(CFG_RELEASE, rel_d);
    no_idle <= quiet;
    lim = (act == 0) ? 1 : ((act > LANES) ? LANES : act);
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      b    = 3'($urandom_range(0, lim - 1));
      if (roll < 25 && $urandom_range(0, 1)) held_low[b] = ~held_low[b];
      pins = ~held_low;
      // add contact bounce now and then
      if ($urandom_range(0, 7) == 0) pins = pins ^ 8'($urandom);
      if (roll < 25)      offer(mk(REQ_EDGE, b, pins));
      else if (roll < 65) offer(mk(REQ_TICK, 3'($urandom), pins));
      else if (roll < 88) offer(mk(REQ_READ, 3'($urandom), pins));
      else if (roll < 93) offer(mk(REQ_NONE, 3'($urandom), 8'($urandom)));
      else                offer(mk(REQ_EDGE, 3'($urandom), pins));
    end
    no_idle <= 1'b0;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: one button in use
    offer(mk(REQ_READ, 3'd0, 8'hFF));   // read with nothing pending
    offer(mk(REQ_EDGE, 3'd5, 8'hFF));   // edge on a button not in use
    offer(mk(REQ_NONE, 3'd7, 8'h00));   // unused request code
    offer(mk(REQ_EDGE, 3'd0, 8'hFE));   // arm button 0 with the reset press delay

    // Clamp to all lanes, a zero press delay acts as one tick, unknown index dropped
    write_reg_port(CFG_ACTIVE, 16'd15);
    write_reg_port(CFG_PRESS, 16'd0);
    write_reg_port(CFG_RELEASE, 16'd1);
    write_reg_port(CFG_NONE, 16'hFFFF);
    offer(mk(REQ_EDGE, 3'd7, 8'h00));
    offer(mk(REQ_EDGE, 3'd7, 8'h00));   // edge while uncertain
    offer(mk(REQ_TICK, 3'd0, 8'h7F));   // button 7 sampled low: press
    offer(mk(REQ_EDGE, 3'd7, 8'h7F));   // edge while down
    offer(mk(REQ_READ, 3'd2, 8'h7F));   // status with button 7 down
    offer(mk(REQ_READ, 3'd2, 8'h7F));   // flag already cleared
    offer(mk(REQ_TICK, 3'd0, 8'hFF));   // release
    offer(mk(REQ_EDGE, 3'd6, 8'hBF));
    offer(mk(REQ_TICK, 3'd1, 8'hFF));   // bounce: uncertain back to up
    offer(mk(REQ_EDGE, 3'd6, 8'hBF));

    // Shrink to two buttons while button 6 is still timing; upper bits ignored
    write_reg_port(CFG_ACTIVE, 16'hFFF2);
    offer(mk(REQ_TICK, 3'd5, 8'h00));   // button 6 goes down outside the range
    offer(mk(REQ_EDGE, 3'd6, 8'h00));
    offer(mk(REQ_READ, 3'd6, 8'h00));   // mask must leave button 6 out

    // No buttons in use
    write_reg_port(CFG_ACTIVE, 16'd0);
    offer(mk(REQ_EDGE, 3'd0, 8'h00));
    offer(mk(REQ_TICK, 3'd3, 8'h00));
    offer(mk(REQ_READ, 3'd4, 8'h00));

    // Random activity over several settings, extremes included; each phase starts
    // with the sender paused until the block has drained
    run_phase(4'd8, 16'd1, 16'd1, 120, 1'b0);
    run_phase(4'd8, 16'd3, 16'd2, 120, 1'b1);
    run_phase(4'd4, 16'd0, 16'd0, 100, 1'b0);
    run_phase(4'd15, 16'd2, 16'd4, 100, 1'b0);
    run_phase(4'd1, 16'd5, 16'd3, 80, 1'b0);
    run_phase(4'd0, 16'd1, 16'd1, 40, 1'b0);
    run_phase(4'd8, 16'hFFFF, 16'hFFFF, 30, 1'b0);
    run_phase(4'($urandom_range(1, 8)), 16'($urandom_range(1, 6)),
              16'($urandom_range(1, 8)), 100, 1'b0);
    run_phase(4'd6, 16'd1, 16'd2, 110, 1'b0);

    settle();
    $display("Covered %0d requests and %0d status transactions checked,", sb.requests,
             sb.checked);
    $display("with %0d debounced presses and %0d status reads that returned a mask.",
             sb.presses, sb.status_reads);
    if (sb.errors == 0 && sb.awaited_status.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
